// ===== sv/ppc_pkg.sv =====
package ppc_pkg;

    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] REG_GOAL_X        = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_GOAL_Y        = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_GOAL_HEADING  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_GAIN_DISTANCE = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_GAIN_ALPHA    = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_GAIN_BETA     = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_STOP_DISTANCE = 3'd6;

    // CORDIC datapath: |dx|,|dy| < 2^17, times 2^12, gain growth < 2^1.
    localparam int unsigned XyW = 33;
    localparam int unsigned ZW = 28;

    localparam logic signed [ZW-1:0] PI_Q24 = 28'sd52707179;
    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
    localparam logic signed [15:0] PI_Q12 = 16'sd12868;
    localparam logic signed [15:0] TWO_PI_Q12 = 16'sd25736;
    localparam logic signed [15:0] DEADBAND_Q12 = 16'sd123;
    localparam int LinMax = 819;
    localparam int AngMax = 4096;

    // Front-end request into the queue.
    typedef struct packed {
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic signed [14:0] heading;
    } t_req;

    typedef struct packed {
        logic [9:0]         linear_speed;
        logic signed [13:0] angular_speed;
        logic               goal_reached;
    } t_res;

    function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:  v = 28'sd13176795;
            5'd1:  v = 28'sd7778716;
            5'd2:  v = 28'sd4110060;
            5'd3:  v = 28'sd2086331;
            5'd4:  v = 28'sd1047214;
            5'd5:  v = 28'sd524117;
            5'd6:  v = 28'sd262123;
            5'd7:  v = 28'sd131069;
            5'd8:  v = 28'sd65536;
            5'd9:  v = 28'sd32768;
            5'd10: v = 28'sd16384;
            5'd11: v = 28'sd8192;
            5'd12: v = 28'sd4096;
            5'd13: v = 28'sd2048;
            5'd14: v = 28'sd1024;
            5'd15: v = 28'sd512;
            5'd16: v = 28'sd256;
            5'd17: v = 28'sd128;
            5'd18: v = 28'sd64;
            5'd19: v = 28'sd32;
            5'd20: v = 28'sd16;
            5'd21: v = 28'sd8;
            5'd22: v = 28'sd4;
            5'd23: v = 28'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] shape_angle(input logic signed [15:0] a);
        logic signed [15:0] v;
        v = a;
        if (v > -DEADBAND_Q12 && v < DEADBAND_Q12) v = '0;
        if (v > PI_Q12) v = v - TWO_PI_Q12;
        if (v < -PI_Q12) v = v + TWO_PI_Q12;
        return v;
    endfunction

endpackage

// ===== sv/ppc_front.sv =====
module ppc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_position_x,
    input  logic signed [15:0] i_position_y,
    input  logic signed [14:0] i_heading,
    input  logic signed [15:0] i_goal_x,
    input  logic signed [15:0] i_goal_y,
    output logic               o_valid,
    input  logic               i_ready,
    output ppc_pkg::t_req      o_req
);
    // Two-entry queue; differences are formed on entry.
    logic [1:0]    r_vld;
    ppc_pkg::t_req r_q [2];
    ppc_pkg::t_req w_new;

    assign w_new.dx = 17'(i_goal_x) - 17'(i_position_x);
    assign w_new.dy = 17'(i_goal_y) - 17'(i_position_y);
    assign w_new.heading = i_heading;

    assign o_ready = !r_vld[1];
    assign o_valid = r_vld[0];
    assign o_req = r_q[0];

    logic w_push, w_pop;
    assign w_push = i_valid && o_ready;
    assign w_pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            case ({w_push, w_pop})
                2'b10: r_vld <= {r_vld[0], 1'b1};
                2'b01: r_vld <= {1'b0, r_vld[1]};
                default: r_vld <= r_vld;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_q[0] <= r_vld[1] ? r_q[1] : w_new;
        end else if (w_push && !r_vld[0]) begin
            r_q[0] <= w_new;
        end
        if (w_push && (r_vld[0] && !w_pop)) begin
            r_q[1] <= w_new;
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> r_vld[0]) else $error("queue hole");
    a_full_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && !w_pop) |=> r_vld[1]) else $error("full queue lost entry");
    a_pop_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld == 2'b11 && w_pop) |=> r_vld[0]) else $error("queue drained early");
`endif
endmodule

// ===== sv/ppc_back.sv =====
module ppc_back #(
    parameter int STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  ppc_pkg::t_req      i_req,
    input  logic signed [14:0] i_goal_heading,
    input  logic signed [15:0] i_gain_distance,
    input  logic signed [15:0] i_gain_alpha,
    input  logic signed [15:0] i_gain_beta,
    input  logic [14:0]        i_stop_distance,
    output logic               o_valid,
    input  logic               i_ready,
    output ppc_pkg::t_res      o_res
);
    localparam int XyW = ppc_pkg::XyW;
    localparam int ZW = ppc_pkg::ZW;
    localparam int Depth = STAGES + 5;

    // Stalling pipeline: whole pipe advances when the output is free.
    logic w_adv;
    logic [Depth-1:0] r_v;
    assign w_adv = !r_v[Depth-1] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_v[Depth-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[Depth-2:0], i_valid};
        end
    end

    // Stage 0: pre-rotation into right half plane.
    logic signed [XyW-1:0] r_x [STAGES+1];
    logic signed [XyW-1:0] r_y [STAGES+1];
    logic signed [ZW-1:0]  r_z [STAGES+1];
    logic                  r_zero [STAGES+1];
    logic signed [14:0]    r_th [STAGES+1];

    logic signed [XyW-1:0] w_x0, w_y0;
    assign w_x0 = XyW'(i_req.dx) <<< 12;
    assign w_y0 = XyW'(i_req.dy) <<< 12;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_zero[0] <= (i_req.dx == '0) && (i_req.dy == '0);
            r_th[0] <= i_req.heading;
            if (i_req.dx < 0) begin
                r_x[0] <= -w_x0;
                r_y[0] <= -w_y0;
                r_z[0] <= (i_req.dy >= 0) ? ppc_pkg::PI_Q24 : -ppc_pkg::PI_Q24;
            end else begin
                r_x[0] <= w_x0;
                r_y[0] <= w_y0;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_cordic
        logic signed [XyW-1:0] w_xs, w_ys;
        assign w_xs = r_x[g] >>> g;
        assign w_ys = r_y[g] >>> g;
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_zero[g+1] <= r_zero[g];
                r_th[g+1] <= r_th[g];
                if (r_y[g] >= 0) begin
                    r_x[g+1] <= r_x[g] + w_ys;
                    r_y[g+1] <= r_y[g] - w_xs;
                    r_z[g+1] <= r_z[g] + ppc_pkg::atan_q24(5'(g));
                end else begin
                    r_x[g+1] <= r_x[g] - w_ys;
                    r_y[g+1] <= r_y[g] + w_xs;
                    r_z[g+1] <= r_z[g] - ppc_pkg::atan_q24(5'(g));
                end
            end
        end
    end

    // Stage A: gain product (split 33x30 into two halves) and angles.
    logic [XyW-1:0] w_xu;
    assign w_xu = unsigned'(r_x[STAGES]);
    logic [47:0] r_plo;
    logic [47:0] r_phi;
    logic signed [15:0] r_alpha, r_beta;
    logic signed [15:0] w_bear, w_alpha, w_beta;
    logic signed [ZW-1:0] w_zr;
    assign w_zr = r_zero[STAGES] ? '0 : r_z[STAGES] + ZW'(2048);
    assign w_bear = 16'(w_zr >>> 12);
    assign w_alpha = w_bear - 16'(r_th[STAGES]);
    assign w_beta = 16'(i_goal_heading) - w_alpha - 16'(r_th[STAGES]);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_plo <= 48'({1'b0, w_xu[16:0]}) * 48'(ppc_pkg::INV_GAIN_Q30);
            r_phi <= 48'(w_xu[XyW-1:17]) * 48'(ppc_pkg::INV_GAIN_Q30);
            r_alpha <= ppc_pkg::shape_angle(w_alpha);
            r_beta <= ppc_pkg::shape_angle(w_beta);
        end
    end

    // Stage B: distance (up to 17 bits on a full-scale diagonal), angular products.
    logic [63:0] w_prod;
    assign w_prod = {r_phi[46:0], 17'd0} + 64'(r_plo) + (64'd1 << 41);
    logic [16:0] r_dist;
    logic signed [31:0] r_pa, r_pb;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dist <= w_prod[58:42];
            r_pa <= 32'(i_gain_alpha) * 32'(r_alpha);
            r_pb <= 32'(i_gain_beta) * 32'(r_beta);
        end
    end

    // Stage C: linear product, angular sum, stop-distance compare.
    logic signed [33:0] r_lin;
    logic signed [33:0] r_ang;
    logic               r_reached;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lin <= (34'(i_gain_distance) * 34'(signed'({1'b0, r_dist}))) + 34'sd512;
            r_ang <= 34'(r_pa) + 34'(r_pb) + 34'sd2048;
            r_reached <= r_dist < {2'b0, i_stop_distance};
        end
    end

    // Stage D: round, saturate, output register.
    logic signed [33:0] w_lin, w_ang;
    assign w_lin = r_lin >>> 10;
    assign w_ang = r_ang >>> 12;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_res.goal_reached <= r_reached;
            if (r_reached) begin
                o_res.linear_speed <= '0;
                o_res.angular_speed <= '0;
            end else begin
                if (w_lin < 0) o_res.linear_speed <= '0;
                else if (w_lin > 34'(ppc_pkg::LinMax))
                    o_res.linear_speed <= 10'(ppc_pkg::LinMax);
                else o_res.linear_speed <= w_lin[9:0];
                if (w_ang > 34'(ppc_pkg::AngMax))
                    o_res.angular_speed <= 14'(ppc_pkg::AngMax);
                else if (w_ang < -34'(ppc_pkg::AngMax))
                    o_res.angular_speed <= -14'(ppc_pkg::AngMax);
                else o_res.angular_speed <= w_ang[13:0];
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_res))) else $error("result dropped");
    a_reached_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.goal_reached) |-> (o_res.linear_speed == '0
            && o_res.angular_speed == '0)) else $error("speed at goal");
    a_lin_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_res.linear_speed <= 10'(ppc_pkg::LinMax)) else $error("lin cap");
`endif
endmodule

// ===== sv/polar_pose_controller_core.sv =====
// Polar pose controller: one drive command per odometry request.
// Slave channel: i_s_tdata = {heading[46:32], position_y[31:16], position_x[15:0]}.
// Master channel: o_m_tdata = {angular_speed[23:10], linear_speed[9:0]};
//   o_m_tuser = goal_reached.
// Config: i_cfg_we/i_cfg_idx/i_cfg_data write goal, gains and stop distance;
//   write only while idle. Unknown indexes are ignored.
// Structure: a front end forms goal offsets into a two-entry queue; the back end
//   is a stalling pipeline (vectoring CORDIC of CORDIC_STAGES stages, then
//   gain multiply, products, round and clamp) ending in an output register.
// Throughput: one request per cycle while the receiver accepts results.
// Receiver stall: the back pipe freezes, the queue fills, then i_s_tready
//   drops; no request is lost.
// Reset (synchronous, active low): empties queue and pipe, loads default
//   goal (1,1 m, heading 0.785 rad), gains and stop distance.
module polar_pose_controller_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // position_x, position_y, heading, zero pad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // linear_speed, angular_speed
    output logic        o_m_tuser,   // goal_reached
    input  logic        i_cfg_we,
    input  logic [ppc_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [ppc_pkg::CfgDataW-1:0] i_cfg_data
);
    logic signed [15:0] r_goal_x, r_goal_y, r_gain_d, r_gain_a, r_gain_b;
    logic signed [14:0] r_goal_h;
    logic [14:0]        r_stop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x <= 16'sd1024;
            r_goal_y <= 16'sd1024;
            r_goal_h <= 15'sd3217;
            r_gain_d <= 16'sd5734;
            r_gain_a <= 16'sd7373;
            r_gain_b <= -16'sd4915;
            r_stop   <= 15'd102;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ppc_pkg::REG_GOAL_X:        r_goal_x <= i_cfg_data;
                ppc_pkg::REG_GOAL_Y:        r_goal_y <= i_cfg_data;
                ppc_pkg::REG_GOAL_HEADING:  r_goal_h <= i_cfg_data[14:0];
                ppc_pkg::REG_GAIN_DISTANCE: r_gain_d <= i_cfg_data;
                ppc_pkg::REG_GAIN_ALPHA:    r_gain_a <= i_cfg_data;
                ppc_pkg::REG_GAIN_BETA:     r_gain_b <= i_cfg_data;
                ppc_pkg::REG_STOP_DISTANCE: r_stop   <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    logic          w_q_valid, w_q_ready;
    ppc_pkg::t_req w_req;
    ppc_pkg::t_res w_res;

    ppc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_position_x (i_s_tdata[15:0]),
        .i_position_y (i_s_tdata[31:16]),
        .i_heading    (i_s_tdata[46:32]),
        .i_goal_x     (r_goal_x),
        .i_goal_y     (r_goal_y),
        .o_valid      (w_q_valid),
        .i_ready      (w_q_ready),
        .o_req        (w_req)
    );

    ppc_back #(.STAGES(CORDIC_STAGES)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_q_valid),
        .o_ready         (w_q_ready),
        .i_req           (w_req),
        .i_goal_heading  (r_goal_h),
        .i_gain_distance (r_gain_d),
        .i_gain_alpha    (r_gain_a),
        .i_gain_beta     (r_gain_b),
        .i_stop_distance (r_stop),
        .o_valid         (o_m_tvalid),
        .i_ready         (i_m_tready),
        .o_res           (w_res)
    );

    assign o_m_tdata = {w_res.angular_speed, w_res.linear_speed};
    assign o_m_tuser = w_res.goal_reached;
endmodule

// ===== tb/polar_pose_controller_core_tb.sv =====
module polar_pose_controller_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Command expected for one odometry request.
    typedef struct {
        logic [9:0]         lin;
        logic signed [13:0] ang;
        logic               reached;
    } t_cmd;

    // Holds the commands still owed by the block, oldest first.
    class cmd_scoreboard;
        t_cmd pending[$];
        int   errors;

        function void note_request(t_cmd c);
            pending.push_back(c);
        endfunction

        function void check_command(logic [9:0] lin, logic signed [13:0] ang, logic reached);
            t_cmd e;
            if (pending.size() == 0) begin
                $error("command with none pending: lin=%0d ang=%0d reached=%0d",
                       lin, ang, reached);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (lin !== e.lin) begin
                $error("linear_speed: expected %0d, actual %0d", e.lin, lin);
                errors++;
            end
            if (ang !== e.ang) begin
                $error("angular_speed: expected %0d, actual %0d", e.ang, ang);
                errors++;
            end
            if (reached !== e.reached) begin
                $error("goal_reached: expected %0d, actual %0d", e.reached, reached);
                errors++;
            end
        endfunction
    endclass

    localparam int Stages = 16;
    localparam int Latency = Stages + 5;
    localparam longint CycleLimit = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [47:0] i_s_tdata;   // position_x, position_y, heading, zero pad
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;   // linear_speed, angular_speed
    logic        o_m_tuser;   // goal_reached
    logic        i_cfg_we;
    logic [ppc_pkg::CfgIdxW-1:0]  i_cfg_idx;
    logic [ppc_pkg::CfgDataW-1:0] i_cfg_data;

    polar_pose_controller_core #(.CORDIC_STAGES(Stages)) u_dut (.*);

    // Controller registers as the model sees them.
    logic signed [15:0] goal_x, goal_y, gain_d, gain_a, gain_b;
    logic signed [14:0] goal_hdg;
    logic [14:0]        stop_dist;

    // Idle odds, in percent.
    int send_idle, recv_idle;
    longint cycles;
    cmd_scoreboard sb;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop on a hung handshake.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint wrap_angle(longint a);
        if (a > -123 && a < 123) a = 0;
        if (a > 12868) a -= 25736;
        if (a < -12868) a += 25736;
        return a;
    endfunction

    // Drive command for one odometry sample.
    function automatic t_cmd steer_command(logic signed [15:0] px, logic signed [15:0] py,
                                           logic signed [14:0] hdg);
        longint dx, dy, x, y, z, xs, ys, th, brg, alpha, beta, lin, ang;
        longint unsigned dist_q10;
        longint atan_q24[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
            262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
            256, 128, 64, 32, 16, 8, 4, 2};
        t_cmd c;
        dx = longint'(goal_x) - longint'(px);
        dy = longint'(goal_y) - longint'(py);
        th = longint'(hdg);
        x = dx * 4096;
        y = dy * 4096;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? 52707179 : -52707179;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < Stages; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += atan_q24[i];
            end else begin
                x -= ys; y += xs; z -= atan_q24[i];
            end
        end
        if (dx == 0 && dy == 0) z = 0;
        dist_q10 = (longint'(x) * 652032874 + (longint'(1) << 41)) >> 42;
        brg = floor_shift(z + 2048, 12);
        alpha = brg - th;
        beta = longint'(goal_hdg) - alpha - th;
        alpha = wrap_angle(alpha);
        beta = wrap_angle(beta);
        lin = floor_shift(longint'(gain_d) * longint'(dist_q10) + 512, 10);
        if (lin < 0) lin = 0;
        if (lin > 819) lin = 819;
        ang = floor_shift(longint'(gain_a) * alpha + longint'(gain_b) * beta + 2048, 12);
        if (ang > 4096) ang = 4096;
        if (ang < -4096) ang = -4096;
        if (dist_q10 < longint'(stop_dist)) begin
            c.lin = '0; c.ang = '0; c.reached = 1'b1;
        end else begin
            c.lin = lin[9:0]; c.ang = ang[13:0]; c.reached = 1'b0;
        end
        return c;
    endfunction

    // Receiver: random backpressure, check on every accepted command.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready)
                sb.check_command(o_m_tdata[9:0], o_m_tdata[23:10], o_m_tuser);
            i_m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // One write on the config port, then write enable low again; updates the model copy.
    task automatic write_reg(logic [ppc_pkg::CfgIdxW-1:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            ppc_pkg::REG_GOAL_X:        goal_x = val;
            ppc_pkg::REG_GOAL_Y:        goal_y = val;
            ppc_pkg::REG_GOAL_HEADING:  goal_hdg = val[14:0];
            ppc_pkg::REG_GAIN_DISTANCE: gain_d = val;
            ppc_pkg::REG_GAIN_ALPHA:    gain_a = val;
            ppc_pkg::REG_GAIN_BETA:     gain_b = val;
            ppc_pkg::REG_STOP_DISTANCE: stop_dist = val[14:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Present one request; optional idle cycles beforehand.
    task automatic send_pose(logic signed [15:0] px, logic signed [15:0] py,
                             logic signed [14:0] hdg);
        while ($urandom_range(99) < send_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {1'b0, hdg, py, px};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_request(steer_command(px, py, hdg));
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
    endtask

    function automatic logic signed [14:0] rand_heading();
        return 15'($signed($urandom_range(25736)) - 12868);
    endfunction

    // Mostly near the goal so the angle logic and stop test see real values.
    task automatic random_poses(int n);
        logic signed [15:0] px, py;
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(9);
            if (r < 6) begin
                px = goal_x + 16'($signed($urandom_range(4000)) - 2000);
                py = goal_y + 16'($signed($urandom_range(4000)) - 2000);
            end else if (r < 8) begin
                px = goal_x + 16'($signed($urandom_range(200)) - 100);
                py = goal_y + 16'($signed($urandom_range(200)) - 100);
            end else begin
                px = 16'($urandom);
                py = 16'($urandom);
            end
            send_pose(px, py, rand_heading());
        end
    endtask

    task automatic random_config();
        write_reg(ppc_pkg::REG_GOAL_X, 16'($signed($urandom_range(8000)) - 4000));
        write_reg(ppc_pkg::REG_GOAL_Y, 16'($signed($urandom_range(8000)) - 4000));
        write_reg(ppc_pkg::REG_GOAL_HEADING, 16'($signed($urandom_range(25736)) - 12868));
        write_reg(ppc_pkg::REG_GAIN_DISTANCE, 16'($urandom));
        write_reg(ppc_pkg::REG_GAIN_ALPHA, 16'($urandom));
        write_reg(ppc_pkg::REG_GAIN_BETA, 16'($urandom));
        write_reg(ppc_pkg::REG_STOP_DISTANCE, 16'($urandom_range(300)));
    endtask

    initial begin
        sb = new();
        cycles = 0;
        send_idle = 6;
        recv_idle = 73;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        // Reset values of the registers.
        goal_x = 1024; goal_y = 1024; goal_hdg = 3217;
        gain_d = 5734; gain_a = 7373; gain_b = -4915; stop_dist = 102;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset goal, zero offset, extremes of fields, deadband, wraps.
        send_pose(16'sd1024, 16'sd1024, 15'sd0);
        send_pose(16'sd1024, 16'sd1024, 15'sd12868);
        send_pose(-16'sd32768, -16'sd32768, -15'sd12868);
        send_pose(16'sd32767, 16'sd32767, 15'sd12868);
        send_pose(16'sd32767, -16'sd32768, 15'sd0);
        send_pose(-16'sd32768, 16'sd32767, 15'sd100);
        send_pose(16'sd2048, 16'sd1024, 15'sd122);
        send_pose(16'sd0, 16'sd1024, -15'sd123);
        send_pose(16'sd0, 16'sd1030, 15'sd0);
        send_pose(16'sd0, 16'sd1018, 15'sd0);
        send_pose(16'sd1000, 16'sd1000, 15'sd500);
        send_pose(16'sd1100, 16'sd1024, 15'sd0);
        send_pose(16'sd1024, 16'sd0, 15'sd6434);
        send_pose(-16'sd1, 16'sd0, 15'sd16383);
        drain();

        // Extreme registers: negative distance gain, full gains, no stop region.
        write_reg(ppc_pkg::REG_GOAL_X, 16'h8000);
        write_reg(ppc_pkg::REG_GOAL_Y, 16'h7fff);
        write_reg(ppc_pkg::REG_GOAL_HEADING, 16'(-12868));
        write_reg(ppc_pkg::REG_GAIN_DISTANCE, 16'h8000);
        write_reg(ppc_pkg::REG_GAIN_ALPHA, 16'h7fff);
        write_reg(ppc_pkg::REG_GAIN_BETA, 16'h8000);
        write_reg(ppc_pkg::REG_STOP_DISTANCE, 16'h0000);
        write_reg(3'd7, 16'hffff);   // unmapped index, ignored
        send_pose(16'sd32767, -16'sd32768, 15'sd12868);
        send_pose(-16'sd32768, 16'sd32767, -15'sd12868);
        send_pose(16'sd0, 16'sd0, 15'sd0);
        send_pose(16'sd12345, -16'sd321, -15'sd7000);
        drain();
        write_reg(ppc_pkg::REG_GOAL_HEADING, 16'sd12868);
        write_reg(ppc_pkg::REG_GAIN_DISTANCE, 16'h7fff);
        write_reg(ppc_pkg::REG_STOP_DISTANCE, 16'h7fff);
        send_pose(16'sd0, 16'sd0, 15'sd0);
        send_pose(-16'sd32768, -16'sd32768, 15'sd3000);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 6 : (phase == 1) ? 73 : 0;
            recv_idle = (phase == 0) ? 73 : (phase == 1) ? 6 : 0;
            for (int s = 0; s < 2; s++) begin
                random_config();
                random_poses(117);
                drain();
            end
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
